@@ rtl/pid_drive_controller_defines.svh @@
// Assertion macros shared by the drive controller modules.
`ifndef PID_DRIVE_CONTROLLER_DEFINES_SVH
`define PID_DRIVE_CONTROLLER_DEFINES_SVH

// Condition this cycle implies consequence in the next cycle.
`define PDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition this cycle implies the signal keeps its value into the next cycle.
`define PDC_ASSERT_HOLD(lbl, ante, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> $stable(sig)) \
    else $error(msg);

`endif

@@ rtl/pdc_pkg.sv @@
// Shared types, constants and helpers of the PID drive controller.
`timescale 1ns / 1ps

package pdc_pkg;

  localparam int GAIN_FRAC_BITS_DEF = 8;
  localparam int INTEGRAL_WIDTH_DEF = 40;

  localparam int DATA_W     = 16;
  localparam int ERR_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 40;

  localparam logic signed [DATA_W-1:0] CEILING_RESET = 16'sd255;
  localparam logic [DATA_W-1:0]        PERIOD_RESET  = 16'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_TARGET      = 3'd3,
    REG_FLOOR       = 3'd4,
    REG_CEILING     = 3'd5,
    REG_MOTOR_MODE  = 3'd6,
    REG_PERIOD      = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d_scaled;
    logic signed [DATA_W-1:0] target_level;
    logic signed [DATA_W-1:0] drive_floor;
    logic signed [DATA_W-1:0] drive_ceiling;
    logic                     signed_motor_mode;
    logic [DATA_W-1:0]        update_period_ms;
  } pdc_cfg_t;

  typedef struct packed {
    logic step;    // an item leaves the input register this cycle
    logic sample;  // that item is a sensor sample
    logic clear;   // set point write: clear loop state
  } upd_ctrl_t;

  // Width of the summed control value: products plus integral, two guard bits.
  function automatic int raw_width(input int iw);
    raw_width = ((iw > 34) ? iw : 34) + 2;
  endfunction

endpackage

@@ rtl/pdc_update.sv @@
// Control update: error, saturating integral, PID sum and the loop state registers.
`timescale 1ns / 1ps
`include "pid_drive_controller_defines.svh"

module pdc_update #(
  parameter int INTEGRAL_WIDTH = pdc_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pdc_pkg::upd_ctrl_t                ctrl,
  input  pdc_pkg::pdc_cfg_t                 cfg,
  input  logic signed [pdc_pkg::DATA_W-1:0] sensor_value,
  output logic                              fire,
  output logic signed [pdc_pkg::raw_width(INTEGRAL_WIDTH)-1:0] raw_sum,
  output logic signed [pdc_pkg::ERR_W-1:0]  current_error
);

  localparam int IW    = INTEGRAL_WIDTH;
  localparam int RAW_W = pdc_pkg::raw_width(INTEGRAL_WIDTH);
  localparam int ACC_W = ((IW > 33) ? IW : 33) + 1;
  localparam logic signed [ACC_W-1:0] IMAX = ACC_W'({1'b0, {(IW-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] IMIN = ~IMAX;

  logic [pdc_pkg::DATA_W-1:0]        ticks_r, ticks_nxt;
  logic signed [IW-1:0]              integ_r, integ_nxt, integ_sat;
  logic signed [pdc_pkg::ERR_W-1:0]  last_err_r, last_err_nxt;
  logic signed [pdc_pkg::ERR_W-1:0]  cur_err_r, cur_err_nxt;
  logic signed [RAW_W-1:0]           raw_r, raw_nxt, raw_calc;

  logic signed [pdc_pkg::DATA_W-1:0] gain_p, gain_i, gain_d, target;
  logic signed [pdc_pkg::ERR_W-1:0]  err;
  logic signed [pdc_pkg::ERR_W:0]    err_diff;
  logic signed [32:0]                prod_p, prod_i;
  logic signed [33:0]                prod_d;
  logic signed [ACC_W-1:0]           acc;
  logic                              due;

  assign gain_p = cfg.gain_p;
  assign gain_i = cfg.gain_i;
  assign gain_d = cfg.gain_d_scaled;
  assign target = cfg.target_level;

  assign err      = pdc_pkg::ERR_W'(sensor_value) - pdc_pkg::ERR_W'(target);
  assign err_diff = (pdc_pkg::ERR_W+1)'(err) - (pdc_pkg::ERR_W+1)'(last_err_r);
  assign prod_p   = gain_p * err;
  assign prod_i   = gain_i * err;
  assign prod_d   = gain_d * err_diff;

  assign acc = ACC_W'(integ_r) + ACC_W'(prod_i);
  always_comb begin
    if (acc > IMAX) begin
      integ_sat = IMAX[IW-1:0];
    end else if (acc < IMIN) begin
      integ_sat = IMIN[IW-1:0];
    end else begin
      integ_sat = acc[IW-1:0];
    end
  end

  assign raw_calc = RAW_W'(prod_p) + RAW_W'(integ_sat) + RAW_W'(prod_d);

  assign due  = (ticks_r >= cfg.update_period_ms);
  assign fire = ctrl.step && ctrl.sample && due;

  always_comb begin
    ticks_nxt    = ticks_r;
    integ_nxt    = integ_r;
    last_err_nxt = last_err_r;
    cur_err_nxt  = cur_err_r;
    raw_nxt      = raw_r;
    if (ctrl.clear) begin
      ticks_nxt    = '0;
      integ_nxt    = '0;
      last_err_nxt = '0;
      cur_err_nxt  = '0;
    end else if (fire) begin
      ticks_nxt    = '0;
      integ_nxt    = integ_sat;
      last_err_nxt = err;
      cur_err_nxt  = err;
      raw_nxt      = raw_calc;
    end else if (ctrl.step && !ctrl.sample && (ticks_r != '1)) begin
      ticks_nxt = ticks_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r    <= '0;
      integ_r    <= '0;
      last_err_r <= '0;
      cur_err_r  <= '0;
      raw_r      <= '0;
    end else begin
      ticks_r    <= ticks_nxt;
      integ_r    <= integ_nxt;
      last_err_r <= last_err_nxt;
      cur_err_r  <= cur_err_nxt;
      raw_r      <= raw_nxt;
    end
  end

  assign raw_sum       = raw_r;
  assign current_error = cur_err_r;

  `PDC_ASSERT_NEXT(a_clear_state, ctrl.clear,
    (integ_r == '0) && (cur_err_r == '0) && (ticks_r == '0), "set point write left state")
  `PDC_ASSERT_NEXT(a_fire_restart, fire && !ctrl.clear,
    (ticks_r == '0) && (last_err_r == cur_err_r), "update did not restart the period")
  `PDC_ASSERT_HOLD(a_integ_idle, !ctrl.step && !ctrl.clear, integ_r,
    "integral moved without an item")

endmodule

@@ rtl/pdc_drive.sv @@
// Drive formation: magnitude, fraction drop, ceiling/floor clamp and motor sign.
`timescale 1ns / 1ps

module pdc_drive #(
  parameter int GAIN_FRAC_BITS = pdc_pkg::GAIN_FRAC_BITS_DEF,
  parameter int INTEGRAL_WIDTH = pdc_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic signed [pdc_pkg::raw_width(INTEGRAL_WIDTH)-1:0] raw_sum,
  input  logic signed [pdc_pkg::ERR_W-1:0]  current_error,
  input  pdc_pkg::pdc_cfg_t                 cfg,
  output logic signed [pdc_pkg::DATA_W-1:0] drive
);

  localparam int RAW_W = pdc_pkg::raw_width(INTEGRAL_WIDTH);

  logic [RAW_W-1:0]                  mag, mag_shift;
  logic signed [RAW_W:0]             mag_s, ceil_x, floor_x, clip_hi, clip_lo;
  logic signed [pdc_pkg::DATA_W-1:0] mag16;

  // Guard bits keep the most negative sum out of reach, so the negate is exact.
  assign mag       = (raw_sum < 0) ? RAW_W'(-raw_sum) : RAW_W'(raw_sum);
  assign mag_shift = mag >> GAIN_FRAC_BITS;
  assign mag_s     = signed'({1'b0, mag_shift});

  assign ceil_x  = (RAW_W+1)'(cfg.drive_ceiling);
  assign floor_x = (RAW_W+1)'(cfg.drive_floor);

  // Floor applied last: it wins when set above the ceiling.
  assign clip_hi = (mag_s >= ceil_x) ? ceil_x : mag_s;
  assign clip_lo = (clip_hi <= floor_x) ? floor_x : clip_hi;
  assign mag16   = clip_lo[pdc_pkg::DATA_W-1:0];

  assign drive = (cfg.signed_motor_mode && (current_error > 0)) ? -mag16 : mag16;

endmodule

@@ rtl/pid_drive_controller.sv @@
// Top level of the PID drive controller: config registers, pipeline and handshake.
`timescale 1ns / 1ps
`include "pid_drive_controller_defines.svh"

// Channel  Dir  tdata (low bit up)                      tuser
// in_      in   sensor_value[15:0]                      kind (0 tick, 1 sample)
// out_     out  drive[15:0], error_now[32:16], zero pad  updated
// cfg_     in   cfg_we / cfg_addr (register) / cfg_wdata, no read-back
//
// Flow: one word per clock while the result register is free or drained; the input register
//   captures the word, the control update writes the loop state as it moves to the middle
//   stage, then the drive clamp fills the result register. The loop state feedback
//   (integral, last error) is in place for the very next word.
// Reset: synchronous active-low rst_n clears the pipeline valids, loop state and registers
//   to their reset values; no clearing pass.
// Stalls: out_tready low with a result waiting freezes the whole pipeline; the input
//   register still takes one word while it is empty.

module pid_drive_controller #(
  parameter int GAIN_FRAC_BITS = pdc_pkg::GAIN_FRAC_BITS_DEF,
  parameter int INTEGRAL_WIDTH = pdc_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pdc_pkg::DATA_W-1:0]          in_tdata,   // [15:0] sensor_value
  input  logic [0:0]                          in_tuser,   // [0] kind
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pdc_pkg::OUT_DATA_W-1:0]      out_tdata,  // [15:0] drive, [32:16] error_now
  output logic [0:0]                          out_tuser   // [0] updated
);

  localparam int RAW_W = pdc_pkg::raw_width(INTEGRAL_WIDTH);

  pdc_pkg::pdc_cfg_t  cfg_r;
  pdc_pkg::upd_ctrl_t upd_ctrl;

  // Pipeline registers.
  logic                              in_valid_r;
  logic                              in_kind_r;
  logic signed [pdc_pkg::DATA_W-1:0] in_sensor_r;
  logic                              mid_valid_r;
  logic                              mid_updated_r;
  logic                              out_valid_r;
  logic signed [pdc_pkg::DATA_W-1:0] out_drive_r;
  logic signed [pdc_pkg::ERR_W-1:0]  out_err_r;
  logic                              out_updated_r;

  logic                              advance;
  logic                              upd_fire;
  logic signed [RAW_W-1:0]           raw_sum;
  logic signed [pdc_pkg::ERR_W-1:0]  current_error;
  logic signed [pdc_pkg::DATA_W-1:0] drive;
  logic                              target_wr;

  // Whole pipeline moves when the result register is free or being drained.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance || !in_valid_r;
  assign target_wr = cfg_we && (pdc_pkg::cfg_idx_t'(cfg_addr) == pdc_pkg::REG_TARGET);

  assign upd_ctrl.step   = advance && in_valid_r;
  assign upd_ctrl.sample = in_kind_r;
  assign upd_ctrl.clear  = target_wr;

  // Configuration registers; unknown indexes cannot occur with a 3-bit index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p            <= '0;
      cfg_r.gain_i            <= '0;
      cfg_r.gain_d_scaled     <= '0;
      cfg_r.target_level      <= '0;
      cfg_r.drive_floor       <= '0;
      cfg_r.drive_ceiling     <= pdc_pkg::CEILING_RESET;
      cfg_r.signed_motor_mode <= 1'b0;
      cfg_r.update_period_ms  <= pdc_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      case (pdc_pkg::cfg_idx_t'(cfg_addr))
        pdc_pkg::REG_GAIN_P:     cfg_r.gain_p            <= cfg_wdata;
        pdc_pkg::REG_GAIN_I:     cfg_r.gain_i            <= cfg_wdata;
        pdc_pkg::REG_GAIN_D:     cfg_r.gain_d_scaled     <= cfg_wdata;
        pdc_pkg::REG_TARGET:     cfg_r.target_level      <= cfg_wdata;
        pdc_pkg::REG_FLOOR:      cfg_r.drive_floor       <= cfg_wdata;
        pdc_pkg::REG_CEILING:    cfg_r.drive_ceiling     <= cfg_wdata;
        pdc_pkg::REG_MOTOR_MODE: cfg_r.signed_motor_mode <= cfg_wdata[0];
        pdc_pkg::REG_PERIOD:     cfg_r.update_period_ms  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      mid_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        mid_valid_r <= in_valid_r;
        out_valid_r <= mid_valid_r;
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
    end
  end

  // Payload registers: capture the input word, then advance the result.
  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_kind_r   <= in_tuser[0];
      in_sensor_r <= in_tdata;
    end
    if (advance) begin
      mid_updated_r <= upd_fire;
      out_drive_r   <= drive;
      out_err_r     <= current_error;
      out_updated_r <= mid_updated_r;
    end
  end

  pdc_update #(
    .INTEGRAL_WIDTH(INTEGRAL_WIDTH)
  ) u_update (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (upd_ctrl),
    .cfg          (cfg_r),
    .sensor_value (in_sensor_r),
    .fire         (upd_fire),
    .raw_sum      (raw_sum),
    .current_error(current_error)
  );

  // Drive is formed from the state left by the item now in the middle stage.
  pdc_drive #(
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
    .INTEGRAL_WIDTH(INTEGRAL_WIDTH)
  ) u_drive (
    .raw_sum      (raw_sum),
    .current_error(current_error),
    .cfg          (cfg_r),
    .drive        (drive)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(pdc_pkg::OUT_DATA_W - pdc_pkg::ERR_W - pdc_pkg::DATA_W){1'b0}},
                       out_err_r, out_drive_r};
  assign out_tuser  = out_updated_r;

  `PDC_ASSERT_NEXT(a_in_hold, in_valid_r && !advance, in_valid_r,
    "input word dropped while stalled")
  `PDC_ASSERT_HOLD(a_in_data_hold, in_valid_r && !advance, in_sensor_r,
    "input word changed while stalled")
  `PDC_ASSERT_NEXT(a_mid_to_out, mid_valid_r && advance, out_valid_r,
    "result lost between middle and result stage")

endmodule

@@ verif/pid_drive_checker.sv @@
// Checker of the PID drive controller: watches every channel, predicts each drive word, compares.
`timescale 1ns / 1ps

module pid_drive_checker #(
  parameter int GAIN_FRAC_BITS = pdc_pkg::GAIN_FRAC_BITS_DEF,
  parameter int INTEGRAL_WIDTH = pdc_pkg::INTEGRAL_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [pdc_pkg::DATA_W-1:0]         in_tdata,   // [15:0] sensor_value
  input  logic [0:0]                         in_tuser,   // [0] kind
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [pdc_pkg::OUT_DATA_W-1:0]     out_tdata,  // [15:0] drive, [32:16] error_now
  input  logic [0:0]                         out_tuser,  // [0] updated
  input  logic                               run_done,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 update_count
);
  import pdc_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic signed [ERR_W-1:0]  error_now;
    logic                     updated;
  } drive_word_t;

  drive_word_t drive_queue[$];
  int mismatches  = 0;
  int outstanding = 0;
  int updates     = 0;
  bit leftover_reported = 1'b0;

  // Shadow of the registers
  longint    kp, ki, kd, target, floor_lvl, ceil_lvl;
  bit        motor_mode;
  logic [15:0] period;

  // Shadow of the loop state
  logic [15:0] ticks;
  longint    integ, last_err, cur_err, raw_acc;

  assign fail_count   = mismatches;
  assign pending      = outstanding;
  assign update_count = updates;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] %s mismatch: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic clear_state();
    kp = 0; ki = 0; kd = 0; target = 0; floor_lvl = 0;
    ceil_lvl = longint'(CEILING_RESET);
    motor_mode = 1'b0;
    period = PERIOD_RESET;
    ticks = '0; integ = 0; last_err = 0; cur_err = 0; raw_acc = 0;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    case (cfg_idx_t'(idx))
      REG_GAIN_P:     kp = longint'($signed(v));
      REG_GAIN_I:     ki = longint'($signed(v));
      REG_GAIN_D:     kd = longint'($signed(v));
      REG_TARGET: begin
        // a new set point restarts the loop, the last sum stays
        target = longint'($signed(v));
        integ = 0; last_err = 0; cur_err = 0; ticks = '0;
      end
      REG_FLOOR:      floor_lvl = longint'($signed(v));
      REG_CEILING:    ceil_lvl = longint'($signed(v));
      REG_MOTOR_MODE: motor_mode = v[0];
      REG_PERIOD:     period = v;
      default: ;
    endcase
  endtask

  // Advance the loop by one word and form the drive it returns.
  function automatic drive_word_t advance_loop(input logic is_sample,
                                               input logic [DATA_W-1:0] value);
    drive_word_t w;
    longint imax, imin, err, acc, mag;
    imax = (longint'(1) <<< (INTEGRAL_WIDTH - 1)) - 1;
    imin = -imax - 1;
    w.updated = 1'b0;
    if (!is_sample) begin
      if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
    end else if (ticks >= period) begin
      err = longint'($signed(value)) - target;
      acc = integ + err * ki;
      if (acc > imax) acc = imax;
      if (acc < imin) acc = imin;
      integ = acc;
      cur_err = err;
      raw_acc = kp * err + integ + kd * (err - last_err);
      last_err = err;
      ticks = '0;
      w.updated = 1'b1;
    end
    mag = (raw_acc < 0) ? -raw_acc : raw_acc;
    mag = mag >>> GAIN_FRAC_BITS;
    if (mag >= ceil_lvl) mag = ceil_lvl;
    if (mag <= floor_lvl) mag = floor_lvl;
    if (motor_mode && cur_err > 0) mag = -mag;
    w.drive = mag[DATA_W-1:0];
    w.error_now = cur_err[ERR_W-1:0];
    return w;
  endfunction

  always @(posedge clk) begin
    drive_word_t got, want;
    if (!rst_n) begin
      clear_state();
      drive_queue.delete();
    end else begin
      if (cfg_we) write_register(cfg_addr, cfg_wdata);
      // results leave before this edge's input can have reached the output
      if (out_tvalid && out_tready) begin
        got.drive     = out_tdata[15:0];
        got.error_now = out_tdata[32:16];
        got.updated   = out_tuser[0];
        if (drive_queue.size() == 0) begin
          report_mismatch("unexpected word, drive", longint'(got.drive), 0);
        end else begin
          want = drive_queue.pop_front();
          if (got.drive !== want.drive)
            report_mismatch("drive", longint'(got.drive), longint'(want.drive));
          if (got.error_now !== want.error_now)
            report_mismatch("error_now", longint'(got.error_now), longint'(want.error_now));
          if (got.updated !== want.updated)
            report_mismatch("updated", longint'(got.updated), longint'(want.updated));
          if (want.updated) updates++;
        end
      end
      if (in_tvalid && in_tready) drive_queue.push_back(advance_loop(in_tuser[0], in_tdata));
      if (run_done && !leftover_reported && drive_queue.size() != 0) begin
        report_mismatch("words never delivered", 0, longint'(drive_queue.size()));
        leftover_reported = 1'b1;
      end
    end
    outstanding = drive_queue.size();
  end

endmodule

@@ verif/pid_drive_controller_tb.sv @@
// Testbench top of the PID drive controller: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module pid_drive_controller_tb;
  import pdc_pkg::*;

  // Input word kinds carried on in_tuser
  localparam bit KIND_TICK   = 1'b0;
  localparam bit KIND_SAMPLE = 1'b1;

  localparam int LATENCY    = 2;     // accept to result valid
  localparam int LONG_HOLD  = 64;    // receiver hold-off that fills the pipeline
  localparam int IDLE_LIMIT = 4000;  // cycles without any handshake before giving up
  localparam int SAT_WORDS  = 270;   // enough full-scale updates to pin the integral
  localparam int TICK_RUN   = 40;    // more ticks than the long period asks for

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DATA_W-1:0] in_tdata = '0;   // [15:0] sensor_value
  logic [0:0]        in_tuser = '0;   // [0] kind
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;   // [15:0] drive, [32:16] error_now, zero pad
  logic [0:0]            out_tuser;   // [0] updated

  logic run_done = 1'b0;
  int   fail_count, pending, update_count;

  // Flow-control knobs shared between the stimulus and the result sink
  bit quiet_in     = 1'b0;  // sender never idles
  bit quiet_out    = 1'b0;  // receiver never stalls
  bit hold_request = 1'b0;  // receiver takes one long hold-off
  int words_sent   = 0;
  int cfg_writes   = 0;
  int idle_cycles  = 0;
  logic [15:0] period_now = PERIOD_RESET;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pid_drive_controller DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  pid_drive_checker drive_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .run_done     (run_done),
    .fail_count   (fail_count),
    .pending      (pending),
    .update_count (update_count)
  );

  // Watchdog: any handshake or register write restarts the count.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // Corner values (both full-scale ends, zero, plus and minus one) five times in eight, else anything.
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  // Small signed gain between minus two and plus two, so the drive stays inside the clamps often.
  function automatic logic [15:0] modest_gain();
    return 16'($urandom_range(0, 1023) - 512);
  endfunction

  // Write one register; the write lands at the next edge, then drop the enable.
  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_writes++;
    if (idx == REG_PERIOD) period_now = value;
  endtask

  // Offer one word after a random gap and hold it until accepted. Valid stays high
  // after the accept so a back-to-back word needs no second assignment.
  task automatic send_word(input bit kind, input logic [15:0] value);
    int gap;
    bit ok;
    gap = quiet_in ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= value;
    // tready only moves after rising edges, so the falling edge shows what the next
    // rising edge will see
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    words_sent++;
  endtask

  // Stop offering, wait for every expected word, then let the pipeline settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Mostly runs of the ticks the period asks for (up to twelve; longer periods get a random
  // count), at times one short, then a sample. The rest is noise: lone ticks and lone samples.
  task automatic run_sequences(input int count);
    int n;
    int t;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 4) != 0) begin
        t = (period_now > 12) ? $urandom_range(0, 12) : int'(period_now);
        if (t > 0 && $urandom_range(0, 5) == 0) t = t - 1;  // one short: sample too early
        repeat (t) begin
          send_word(KIND_TICK, 16'($urandom));
          n++;
        end
        send_word(KIND_SAMPLE, pick_value());
        n++;
      end else begin
        send_word(1'($urandom_range(0, 1)), pick_value());
        n++;
      end
    end
  endtask

  // Draw a new setting; every register on the first pass, about half later on.
  task automatic randomize_config(input bit all_regs);
    logic [15:0] p;
    if (all_regs || $urandom_range(0, 1))
      write_reg(REG_GAIN_P, $urandom_range(0, 2) == 0 ? pick_value() : modest_gain());
    if (all_regs || $urandom_range(0, 1))
      write_reg(REG_GAIN_I, $urandom_range(0, 2) == 0 ? pick_value() : modest_gain());
    if (all_regs || $urandom_range(0, 1))
      write_reg(REG_GAIN_D, $urandom_range(0, 2) == 0 ? pick_value() : modest_gain());
    if (all_regs || $urandom_range(0, 1))
      write_reg(REG_TARGET, $urandom_range(0, 1) ? pick_value() : 16'($urandom_range(0, 200)));
    if (all_regs || $urandom_range(0, 1))
      write_reg(REG_FLOOR, $urandom_range(0, 3) == 0 ? pick_value()
                                                     : 16'($urandom_range(0, 40)));
    if (all_regs || $urandom_range(0, 1))
      write_reg(REG_CEILING, $urandom_range(0, 3) == 0 ? pick_value()
                                                       : 16'($urandom_range(50, 4000)));
    if (all_regs || $urandom_range(0, 1))
      write_reg(REG_MOTOR_MODE, 16'($urandom_range(0, 1)));
    if (all_regs || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 9))
        0:       p = 16'd0;
        1:       p = 16'hFFFF;
        default: p = 16'($urandom_range(1, 6));
      endcase
      write_reg(REG_PERIOD, p);
    end
  endtask

  // Result sink: stall a random number of cycles before each word, or take one long
  // hold-off when the stimulus asks for it. One assignment to tready per edge.
  initial begin : result_sink
    int hold;
    bit got;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        hold = quiet_out ? 0 : $urandom_range(0, 7);
        if (hold > 0) begin
          out_tready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
        out_tready <= 1'b1;
        do begin
          @(negedge clk);
          got = out_tvalid;
          @(posedge clk);
        end while (!got);
      end
    end
  end

  initial begin : stimulus
    int ph;

    // Hold reset, then release it at an edge.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings first. A tick, then a sample long before the default
    // period has elapsed.
    send_word(KIND_TICK, 16'h0000);
    send_word(KIND_SAMPLE, 16'h7FFF);
    wait_drained();

    // Unity gain, wide clamps, motor mode, and a zero period so every sample updates.
    write_reg(REG_GAIN_P, 16'h0100);
    write_reg(REG_GAIN_I, 16'h0010);
    write_reg(REG_GAIN_D, 16'h0080);
    write_reg(REG_TARGET, 16'h0000);
    write_reg(REG_FLOOR, 16'h0000);
    write_reg(REG_CEILING, 16'h7FFF);
    write_reg(REG_MOTOR_MODE, 16'h0001);
    write_reg(REG_PERIOD, 16'h0000);
    send_word(KIND_SAMPLE, 16'h7FFF);
    send_word(KIND_SAMPLE, 16'h8000);
    send_word(KIND_SAMPLE, 16'h0000);
    send_word(KIND_SAMPLE, 16'h0001);
    send_word(KIND_SAMPLE, 16'hFFFF);
    send_word(KIND_TICK, 16'hFFFF);       // drive formed from the stored state
    send_word(KIND_SAMPLE, 16'h1234);
    wait_drained();

    // Lowest set point: largest positive error, then none.
    write_reg(REG_TARGET, 16'h8000);
    send_word(KIND_SAMPLE, 16'h7FFF);
    send_word(KIND_SAMPLE, 16'h8000);
    wait_drained();

    // Highest set point: largest negative error.
    write_reg(REG_TARGET, 16'h7FFF);
    send_word(KIND_SAMPLE, 16'h8000);
    wait_drained();

    // Extreme gains with the floor above the ceiling: the floor must win.
    write_reg(REG_GAIN_P, 16'h8000);
    write_reg(REG_GAIN_I, 16'h7FFF);
    write_reg(REG_GAIN_D, 16'h8000);
    write_reg(REG_FLOOR, 16'd100);
    write_reg(REG_CEILING, 16'd50);
    send_word(KIND_SAMPLE, 16'h7FFF);
    send_word(KIND_SAMPLE, 16'h8000);
    wait_drained();

    // Both clamps at the negative extreme with a zero error: the drive is the most
    // negative value and motor mode leaves it unnegated.
    write_reg(REG_GAIN_P, 16'h7FFF);
    write_reg(REG_FLOOR, 16'h8000);
    write_reg(REG_CEILING, 16'h8000);
    send_word(KIND_SAMPLE, 16'h7FFF);
    wait_drained();

    // Short period: an early sample does nothing, two ticks later it updates.
    write_reg(REG_PERIOD, 16'd2);
    write_reg(REG_FLOOR, 16'h0000);
    write_reg(REG_CEILING, 16'h7FFF);
    send_word(KIND_SAMPLE, 16'h0400);
    send_word(KIND_TICK, 16'h5A5A);
    send_word(KIND_TICK, 16'hA5A5);
    send_word(KIND_SAMPLE, 16'h0400);
    wait_drained();

    // Integral pinned at its positive limit. Back-to-back words into a long output
    // hold-off fill the pipeline and stall the input.
    write_reg(REG_GAIN_P, 16'h0000);
    write_reg(REG_GAIN_I, 16'h7FFF);
    write_reg(REG_GAIN_D, 16'h0000);
    write_reg(REG_TARGET, 16'h8000);
    write_reg(REG_PERIOD, 16'h0000);
    write_reg(REG_MOTOR_MODE, 16'h0000);
    quiet_in = 1'b1;
    quiet_out = 1'b0;
    hold_request = 1'b1;
    repeat (SAT_WORDS) send_word(KIND_SAMPLE, $urandom_range(0, 7) == 0 ? pick_value() : 16'h7FFF);
    wait_drained();

    // Integral pinned at its negative limit, with random idling on both sides.
    write_reg(REG_GAIN_I, 16'h8000);
    write_reg(REG_TARGET, 16'h8000);
    write_reg(REG_MOTOR_MODE, 16'h0001);
    quiet_in = 1'b0;
    repeat (SAT_WORDS) send_word(KIND_SAMPLE, $urandom_range(0, 7) == 0 ? pick_value() : 16'h7FFF);
    wait_drained();

    // Random settings, each followed by a stretch of tick/sample runs.
    for (ph = 0; ph < 10; ph++) begin
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      randomize_config(ph == 0);
      run_sequences(70);
      wait_drained();
    end

    // Long period: run more ticks than it asks for with no idling, then one sample
    // that updates, one that comes too early, a tick and another early sample.
    quiet_in = 1'b1;
    quiet_out = 1'b1;
    write_reg(REG_GAIN_P, 16'h0100);
    write_reg(REG_PERIOD, 16'd30);
    write_reg(REG_TARGET, 16'h0010);
    repeat (TICK_RUN) send_word(KIND_TICK, 16'($urandom));
    send_word(KIND_SAMPLE, 16'h0300);
    send_word(KIND_SAMPLE, 16'h0200);
    send_word(KIND_TICK, 16'h0000);
    send_word(KIND_SAMPLE, 16'h0100);

    // Drain everything, let the block settle, then flag the end to the checker.
    wait_drained();
    run_done <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Run: %0d words in, %0d register writes, %0d control updates checked",
             words_sent, cfg_writes, update_count);
    $display("Covered: extreme errors, clamps, integral limits both ways, long output stall");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
